/* design/spectrum_bin_waterfall_pixel_defines.svh */
// Assertion macros shared by the waterfall pixel RTL files.
// Expects clk and rst_n to be visible in the module that uses them.
`ifndef SPECTRUM_BIN_WATERFALL_PIXEL_DEFINES_SVH
`define SPECTRUM_BIN_WATERFALL_PIXEL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBWP_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBWP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sbwp_pkg.sv */
// Package for the spectrum bin waterfall pixel: widths, reset values, codes,
// the controller/datapath interface structs and the colour ramp function.
// No dependencies.
package sbwp_pkg;

    // Default sample width of the I and Q parts.
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field and state widths.
    localparam int STATE_W  = 48;
    localparam int WEIGHT_W = 8;
    localparam int DIVR_W   = 9;
    localparam int LEVEL_W  = 8;
    localparam int PROD_W   = STATE_W + WEIGHT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Register reset values.
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 8'd3;
    localparam logic [DIVR_W-1:0]   DIVISOR_RESET = 9'd4;
    localparam logic [STATE_W-1:0]  SCALE_RESET   = 48'd1000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_AVG_WEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_DIVISOR = 2'd1;

    // Level ceiling and the colour ramp segments (top two bits of the level).
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [1:0] SEG_BLUE   = 2'b00;
    localparam logic [1:0] SEG_GREEN  = 2'b01;
    localparam logic [1:0] SEG_YELLOW = 2'b10;
    localparam logic [1:0] SEG_ORANGE = 2'b11;
    localparam logic [9:0] ORANGE_G_BASE = 10'd66;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic frame_end;
        logic square;
        logic sum;
        logic div_start;
        logic div_level;
        logic avg_store;
        logic peak_update;
        logic compare;
        logic level_store;
        logic emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic level_sat;
        logic out_blocked;
    } dp_status_t;

    // Four-segment ramp: black, blue, green, yellow, orange.
    function automatic pixel_t colour_of(input logic [LEVEL_W-1:0] v);
        logic [9:0] v4;
        logic [9:0] inv;
        pixel_t     p;
        v4  = {v, 2'b00};
        inv = 10'd255 - {2'b00, v};
        p   = '0;
        unique case (v[7:6])
            SEG_BLUE:
            begin
                p.b = 8'(10'd3 + v4);
            end
            SEG_GREEN:
            begin
                p.g = 8'(v4 - 10'd253);
                p.b = 8'(10'd511 - v4);
            end
            SEG_YELLOW:
            begin
                p.r = 8'(v4 - 10'd509);
                p.g = LEVEL_MAX;
            end
            SEG_ORANGE:
            begin
                p.r = LEVEL_MAX;
                p.g = 8'(ORANGE_G_BASE + 10'd3 * inv);
            end
            default:
            begin
                p = '0;
            end
        endcase
        return p;
    endfunction

endpackage

/* design/sbwp_divider.sv */
// Restoring serial divider, one quotient bit per cycle.
// Used for both the running average and the level scaling; uses only the assertion macro header.
`include "spectrum_bin_waterfall_pixel_defines.svh"

module sbwp_divider #(
    parameter int NUM_W = 57,
    parameter int DEN_W = 48,
    parameter int CNT_W = $clog2(NUM_W + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DEN_W-1:0] rem_init,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [CNT_W-1:0] steps,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;
    logic [DEN_W-1:0] rem_next;

    // One trial subtraction: the remainder stays below the divisor.
    always_comb
    begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        fits     = (trial >= {1'b0, den_reg});
        diff     = trial - {1'b0, den_reg};
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    // Control: busy while steps remain, a single-cycle done at the end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= steps;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            num_reg <= num;
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

    `SBWP_ASSERT_SAME(a_start_when_idle, start, !busy_reg, "divider restarted while busy")
    `SBWP_ASSERT_SAME(a_done_after_busy, done_reg, !busy_reg && $past(busy_reg), "stray divider done")
    `SBWP_ASSERT_NEXT(a_start_sets_busy, start && (steps != '0), busy_reg, "divider failed to start")

endmodule

/* design/sbwp_datapath.sv */
// Datapath of the waterfall pixel: configuration, state registers, squarers,
// the shared serial divider and the output word. Uses sbwp_pkg, sbwp_divider.
`include "spectrum_bin_waterfall_pixel_defines.svh"

module sbwp_datapath #(
    parameter int SAMPLE_BITS = sbwp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sbwp_pkg::dp_cmd_t                 cmd,
    output sbwp_pkg::dp_status_t              status,
    input  logic                              cfg_wr,
    input  logic [sbwp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbwp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]     in_phase,
    input  logic signed [SAMPLE_BITS-1:0]     quadrature,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [sbwp_pkg::LEVEL_W-1:0]      level,
    output logic [7:0]                        red,
    output logic [7:0]                        green,
    output logic [7:0]                        blue
);

    localparam int STATE_W = sbwp_pkg::STATE_W;
    localparam int PROD_W  = sbwp_pkg::PROD_W;
    localparam int LEVEL_W = sbwp_pkg::LEVEL_W;
    localparam int SQ_W    = 2 * SAMPLE_BITS;
    localparam int POW_W   = SQ_W + 1;
    localparam int SUM_W   = ((PROD_W > POW_W) ? PROD_W : POW_W) + 1;
    localparam int CNT_W   = $clog2(SUM_W + 1);

    logic [sbwp_pkg::WEIGHT_W-1:0] weight_reg;
    logic [sbwp_pkg::DIVR_W-1:0]   divisor_reg;
    logic [STATE_W-1:0]            avg_reg;
    logic [STATE_W-1:0]            peak_reg;
    logic [STATE_W-1:0]            scale_reg;

    logic [SAMPLE_BITS-1:0] mag_i_reg;
    logic [SAMPLE_BITS-1:0] mag_q_reg;
    logic [SQ_W-1:0]        sq_i_reg;
    logic [SQ_W-1:0]        sq_q_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [PROD_W-1:0]      scaled_reg;
    logic                   sat_reg;
    logic [LEVEL_W-1:0]     level_reg;

    logic                   out_valid_reg;
    logic [LEVEL_W-1:0]     level_out_reg;
    sbwp_pkg::pixel_t       pixel_reg;

    logic [SAMPLE_BITS-1:0] mag_i;
    logic [SAMPLE_BITS-1:0] mag_q;
    logic [sbwp_pkg::DIVR_W-1:0] divisor_eff;
    logic [STATE_W-1:0]     div_rem_init;
    logic [SUM_W-1:0]       div_num;
    logic [STATE_W-1:0]     div_den;
    logic [CNT_W-1:0]       div_steps;
    logic [SUM_W-1:0]       div_quo;
    logic                   div_done;
    logic [STATE_W-1:0]     avg_sat;

    // Magnitudes of the two's complement samples.
    always_comb
    begin
        mag_i = in_phase[SAMPLE_BITS-1]   ? SAMPLE_BITS'(~in_phase + 1'b1)
                                          : SAMPLE_BITS'(in_phase);
        mag_q = quadrature[SAMPLE_BITS-1] ? SAMPLE_BITS'(~quadrature + 1'b1)
                                          : SAMPLE_BITS'(quadrature);
    end

    // A zero divisor behaves as one.
    assign divisor_eff = (divisor_reg == '0) ? sbwp_pkg::DIVR_W'(1) : divisor_reg;

    // Divider operands: weighted sum over the divisor, or 255*average over the scale.
    always_comb
    begin
        if (cmd.div_level)
        begin
            div_rem_init = scaled_reg[PROD_W-1:LEVEL_W];
            div_num      = {scaled_reg[LEVEL_W-1:0], {(SUM_W - LEVEL_W){1'b0}}};
            div_den      = scale_reg;
            div_steps    = CNT_W'(LEVEL_W);
        end
        else
        begin
            div_rem_init = '0;
            div_num      = sum_reg;
            div_den      = STATE_W'(divisor_eff);
            div_steps    = CNT_W'(SUM_W);
        end
    end

    sbwp_divider #(
        .NUM_W (SUM_W),
        .DEN_W (STATE_W),
        .CNT_W (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .rem_init (div_rem_init),
        .num      (div_num),
        .den      (div_den),
        .steps    (div_steps),
        .quo      (div_quo),
        .done     (div_done)
    );

    // The new average saturates at the top of the state width.
    assign avg_sat = (div_quo[SUM_W-1:STATE_W] != '0) ? {STATE_W{1'b1}}
                                                       : div_quo[STATE_W-1:0];

    // Configuration and persistent state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg  <= sbwp_pkg::WEIGHT_RESET;
            divisor_reg <= sbwp_pkg::DIVISOR_RESET;
            avg_reg     <= '0;
            peak_reg    <= '0;
            scale_reg   <= sbwp_pkg::SCALE_RESET;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    sbwp_pkg::REG_AVG_WEIGHT:  weight_reg  <= cfg_data[sbwp_pkg::WEIGHT_W-1:0];
                    sbwp_pkg::REG_AVG_DIVISOR: divisor_reg <= cfg_data;
                    default:                   ;
                endcase
            end
            if (cmd.frame_end)
            begin
                scale_reg <= (peak_reg == '0) ? STATE_W'(1) : peak_reg;
                peak_reg  <= '0;
            end
            if (cmd.avg_store)
            begin
                avg_reg <= avg_sat;
            end
            if (cmd.peak_update && (avg_reg > peak_reg))
            begin
                peak_reg <= avg_reg;
            end
        end
    end

    // Working registers of one bin.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_i_reg <= mag_i;
            mag_q_reg <= mag_q;
        end
        if (cmd.square)
        begin
            sq_i_reg <= SQ_W'(mag_i_reg) * SQ_W'(mag_i_reg);
            sq_q_reg <= SQ_W'(mag_q_reg) * SQ_W'(mag_q_reg);
            prod_reg <= PROD_W'(avg_reg) * PROD_W'(weight_reg);
        end
        if (cmd.sum)
        begin
            sum_reg <= SUM_W'(prod_reg) + SUM_W'(sq_i_reg) + SUM_W'(sq_q_reg);
        end
        if (cmd.peak_update)
        begin
            scaled_reg <= {avg_reg, {LEVEL_W{1'b0}}} - PROD_W'(avg_reg);
        end
        if (cmd.compare)
        begin
            sat_reg <= (scaled_reg >= {scale_reg, {LEVEL_W{1'b0}}});
        end
        if (cmd.level_store)
        begin
            level_reg <= sat_reg ? sbwp_pkg::LEVEL_MAX : div_quo[LEVEL_W-1:0];
        end
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            level_out_reg <= level_reg;
            pixel_reg     <= sbwp_pkg::colour_of(level_reg);
        end
    end

    assign status.div_done    = div_done;
    assign status.level_sat   = sat_reg;
    assign status.out_blocked = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign level     = level_out_reg;
    assign red       = pixel_reg.r;
    assign green     = pixel_reg.g;
    assign blue      = pixel_reg.b;

    `SBWP_ASSERT_SAME(a_scale_nonzero, 1'b1, scale_reg != '0, "scale reference is zero")
    `SBWP_ASSERT_SAME(a_emit_not_blocked, cmd.emit, !(out_valid_reg && out_stall), "output overwritten")
    `SBWP_ASSERT_NEXT(a_peak_covers_avg, cmd.peak_update, peak_reg >= $past(avg_reg), "peak below average")

endmodule

/* design/sbwp_ctrl.sv */
// Controller state machine of the waterfall pixel: sequences one item at a time
// through the datapath. Uses sbwp_pkg.
`include "spectrum_bin_waterfall_pixel_defines.svh"

module sbwp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 kind,
    output logic                 in_stall,
    input  sbwp_pkg::dp_status_t status,
    output sbwp_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_AVG_STORE,
        ST_PEAK,
        ST_COMPARE,
        ST_LVL_GO,
        ST_LVL_WAIT,
        ST_LEVEL,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // Command decode from the current state.
    always_comb
    begin
        cmd             = '0;
        cmd.load        = accept && !kind;
        cmd.frame_end   = accept && kind;
        cmd.square      = (state_reg == ST_SQUARE);
        cmd.sum         = (state_reg == ST_SUM);
        cmd.div_start   = (state_reg == ST_AVG_GO) ||
                          ((state_reg == ST_LVL_GO) && !status.level_sat);
        cmd.div_level   = (state_reg == ST_LVL_GO);
        cmd.avg_store   = (state_reg == ST_AVG_STORE);
        cmd.peak_update = (state_reg == ST_PEAK);
        cmd.compare     = (state_reg == ST_COMPARE);
        cmd.level_store = (state_reg == ST_LEVEL);
        cmd.emit        = (state_reg == ST_EMIT) && !status.out_blocked;
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && !kind)
                    begin
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE:    state_reg <= ST_SUM;
                ST_SUM:       state_reg <= ST_AVG_GO;
                ST_AVG_GO:    state_reg <= ST_AVG_WAIT;
                ST_AVG_WAIT:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= ST_AVG_STORE;
                    end
                end
                ST_AVG_STORE: state_reg <= ST_PEAK;
                ST_PEAK:      state_reg <= ST_COMPARE;
                ST_COMPARE:   state_reg <= ST_LVL_GO;
                ST_LVL_GO:    state_reg <= status.level_sat ? ST_LEVEL : ST_LVL_WAIT;
                ST_LVL_WAIT:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= ST_LEVEL;
                    end
                end
                ST_LEVEL:     state_reg <= ST_EMIT;
                ST_EMIT:
                begin
                    if (!status.out_blocked)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:      state_reg <= ST_IDLE;
            endcase
        end
    end

    `SBWP_ASSERT_NEXT(a_bin_stalls_input, accept && !kind, in_stall, "bin accepted but input not held off")
    `SBWP_ASSERT_NEXT(a_frame_end_stays_idle, accept && kind, !in_stall, "frame end left idle")
    `SBWP_ASSERT_SAME(a_one_div_start, cmd.div_start, !(cmd.avg_store || cmd.emit), "divider start clash")

endmodule

/* design/spectrum_bin_waterfall_pixel.sv */
// Spectrum bin waterfall pixel top level; uses sbwp_pkg, sbwp_ctrl and sbwp_datapath.
// Bin word: out_valid is set after squaring, summing, the 57-step division of the
// weighted sum, peak update, compare, the 8-step level division (skipped when the level
// saturates) and the output step. No new bin is taken before the last one is emitted; a
// stalled result holds the next bin at its output step. A frame-end word gives no result.
// rst_n clears asynchronously: average and peak to 0, scale to 1000, weight 3, divisor 4.
module spectrum_bin_waterfall_pixel #(
    parameter int SAMPLE_BITS = sbwp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic signed [SAMPLE_BITS-1:0]     in_phase,
    input  logic signed [SAMPLE_BITS-1:0]     quadrature,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sbwp_pkg::LEVEL_W-1:0]      level,
    output logic [7:0]                        red,
    output logic [7:0]                        green,
    output logic [7:0]                        blue,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sbwp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbwp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    sbwp_pkg::dp_cmd_t    cmd;
    sbwp_pkg::dp_status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    sbwp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sbwp_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_phase   (in_phase),
        .quadrature (quadrature),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .level      (level),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule
